// ----- rtl/asra_pkg.sv -----
// shared constants for the angle spike-reject average block
// no dependencies; imported by asra_div, the core, the checker and the bench
`default_nettype none

package asra_pkg;

	localparam int AVG_DEPTH_DEF = 8;
	localparam int RAW_W         = 14;
	localparam int ANGLE_W       = 16;
	localparam int TDATA_IN_W    = 16;
	localparam int TDATA_OUT_W   = 16;

	// angle = floor(raw * 36000 / 16384)
	localparam int SCALE_NUM   = 36000;
	localparam int SCALE_SHIFT = 14;
	localparam int PROD_W      = RAW_W + 16;
	localparam int ANGLE_MAX   = 35997;

	// outlier test only runs once this many samples are held
	localparam int MIN_FILL = 3;

	// configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 16;
	localparam int RUN_W      = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_RUN_LIMIT = 1'd1;
	localparam logic [THR_W-1:0]     THR_RESET           = 16'd500;
	localparam logic [RUN_W-1:0]     RUN_LIMIT_RESET     = 8'd3;

endpackage

`default_nettype wire

// ----- rtl/asra_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module asra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/asra_div.sv -----
// restoring divider, one quotient bit per cycle, for sum / fill count
// depends on asra_pkg
`default_nettype none

module asra_div
	import asra_pkg::*;
#(
	parameter int NUM_W = 19,
	parameter int DEN_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output      logic             done,
	output      logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic             ge;
	logic [DEN_W:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// remainder stays below the divisor, so it fits DEN_W bits
				rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/angle_spike_reject_average_core.sv -----
// Angle spike-rejecting moving average.
// s_* channel: one item per raw 14-bit angle; m_* channel: one item per input,
// holding the mean in hundredths of a degree and a held flag in m_tuser.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 spike_threshold,
// index 1 spike_run_limit; write only while the block is idle.
// Each input is scaled and, once MIN_FILL samples are held, tested against
// the cached mean; a held outlier outputs that mean, any other sample is
// written into the ring ram (the entry it replaces is read first and, once
// the ring is full, taken out of the running sum); the new mean comes from
// a one-bit-per-cycle divider. Stored samples pass the scale, check, update
// and divide states, rejected ones go from check to output. One item is in
// work at a time, s_tready is high only while idle. The result sits in an
// output register, so the next item is taken while it waits; if m_tready stays
// low the block stalls at the end of the next item until the register frees.
// Reset clears pointer, fill count, outlier run and running sum and loads
// the register defaults (threshold 500, run limit 3); the ring needs no
// clearing since only entries written since the last flush are used.
// depends on asra_pkg, asra_ram, asra_div
`default_nettype none

module angle_spike_reject_average_core
	import asra_pkg::*;
#(
	parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// config write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // [13:0] raw_angle
	// result items
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [TDATA_OUT_W-1:0] m_tdata,   // [15:0] filtered_angle
	output      logic                   m_tuser    // [0] spike_held
);

	localparam int PTR_W = $clog2(AVG_DEPTH);
	localparam int CNT_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W = ANGLE_W + $clog2(AVG_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_CHECK,
		ST_UPDATE,
		ST_DIVIDE,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [RAW_W-1:0]    raw_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [ANGLE_W-1:0]  mean_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PTR_W-1:0]    wp_q;
	logic [CNT_W-1:0]    fill_q;
	logic [RUN_W-1:0]    run_q;
	logic [THR_W-1:0]    thr_q;
	logic [RUN_W-1:0]    limit_q;
	logic [ANGLE_W-1:0]  res_angle_q;
	logic                res_held_q;
	logic                out_valid_q;
	logic [ANGLE_W-1:0]  out_angle_q;
	logic                out_held_q;

	logic [PROD_W-1:0]   prod;
	logic [ANGLE_W-1:0]  ram_rdata;
	logic                full;
	logic [ANGLE_W-1:0]  deviation;
	logic                outlier;
	logic [RUN_W-1:0]    run_inc;
	logic [SUM_W-1:0]    old_val;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    fill_next;
	logic [PTR_W-1:0]    wp_next;
	logic                div_done;
	logic [SUM_W-1:0]    div_quo;
	logic                out_load;

	always_comb begin
		prod      = PROD_W'(raw_q) * PROD_W'(SCALE_NUM);
		full      = fill_q == CNT_W'(AVG_DEPTH);
		deviation = (angle_q > mean_q) ? angle_q - mean_q : mean_q - angle_q;
		outlier   = deviation > thr_q;
		run_inc   = run_q + 1'b1;
		// replaced entry leaves the running sum only once the ring is full
		old_val   = full ? SUM_W'(ram_rdata) : '0;
		sum_next  = sum_q - old_val + SUM_W'(angle_q);
		fill_next = full ? fill_q : fill_q + 1'b1;
		wp_next   = (wp_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	end

	asra_ram #(
		.WIDTH (ANGLE_W),
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPDATE),
		.waddr (wp_q),
		.wdata (angle_q),
		.re    (state_q == ST_SCALE),
		.raddr (wp_q),
		.rdata (ram_rdata)
	);

	asra_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_UPDATE),
		.dividend (sum_next),
		.divisor  (fill_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			raw_q       <= '0;
			angle_q     <= '0;
			mean_q      <= '0;
			sum_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			run_q       <= '0;
			thr_q       <= THR_RESET;
			limit_q     <= RUN_LIMIT_RESET;
			res_angle_q <= '0;
			res_held_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_angle_q <= '0;
			out_held_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPIKE_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					REG_SPIKE_RUN_LIMIT: limit_q <= cfg_data[RUN_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_angle_q <= res_angle_q;
				out_held_q  <= res_held_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						raw_q   <= s_tdata[RAW_W-1:0];
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					angle_q <= prod[SCALE_SHIFT +: ANGLE_W];
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_UPDATE;
					if (fill_q >= CNT_W'(MIN_FILL)) begin
						if (outlier) begin
							if (run_inc < limit_q) begin
								run_q       <= run_inc;
								res_angle_q <= mean_q;
								res_held_q  <= 1'b1;
								state_q     <= ST_OUT;
							end else begin
								// sustained move: flush and restart from this sample
								run_q  <= '0;
								fill_q <= '0;
								wp_q   <= '0;
								sum_q  <= '0;
							end
						end else begin
							run_q <= '0;
						end
					end
				end
				ST_UPDATE: begin
					sum_q   <= sum_next;
					fill_q  <= fill_next;
					wp_q    <= wp_next;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						mean_q      <= div_quo[ANGLE_W-1:0];
						res_angle_q <= div_quo[ANGLE_W-1:0];
						res_held_q  <= 1'b0;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_angle_q;
	assign m_tuser  = out_held_q;

endmodule

`default_nettype wire

// ----- rtl/asra_checker.sv -----
// port-level checks for the angle spike-reject average block, bound to the top
// depends on asra_pkg and angle_spike_reject_average_core
`default_nettype none

module asra_checker
	import asra_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [TDATA_OUT_W-1:0] m_tdata,
	input wire logic                   m_tuser
);

	// stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous item in work");

	// a new result is only loaded from the busy output state
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in work");

	// mean of scaled angles never leaves the scaled range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= TDATA_OUT_W'(ANGLE_MAX))
		else $error("filtered angle out of range");

endmodule

bind angle_spike_reject_average_core asra_checker u_asra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for angle_spike_reject_average_core: directed and random angle items,
// each result compared against a bit-exact spike-reject moving-average model kept in the bench
// depends on asra_pkg and the core rtl

module tb;
	import asra_pkg::*;

	localparam int DEPTH          = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RAND_PHASES    = 10;
	localparam int PHASE_ITEMS    = 93;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               held;
	} mean_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata   = '0;   // [13:0] raw_angle
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;          // [15:0] filtered_angle
	logic                   m_tuser;          // [0] spike_held

	always #5 clk = ~clk;

	angle_spike_reject_average_core #(
		.AVG_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// filter state mirrored in the bench
	logic [ANGLE_W-1:0] win_ring [DEPTH];
	int unsigned        win_wr_ptr = 0;
	int unsigned        win_fill   = 0;
	logic [RUN_W-1:0]   spike_run  = '0;
	logic [THR_W-1:0]   thr_reg    = THR_RESET;
	logic [RUN_W-1:0]   lim_reg    = RUN_LIMIT_RESET;

	logic [RAW_W-1:0] raw_backlog [$];
	mean_result_t     mean_expect_q [$];
	int unsigned      err_count    = 0;
	int unsigned      quiet_cycles = 0;
	logic             s_took       = 1'b0;
	logic             m_took       = 1'b0;
	int unsigned      s_gap        = 0;
	int unsigned      m_stall_left = 0;
	bit               s_idle_on    = 1'b1;
	bit               m_idle_on    = 1'b1;
	int unsigned      walk_base    = 8000;

	function automatic int unsigned window_mean();
		int unsigned acc;
		acc = 0;
		if (win_fill == 0)
			return 0;
		for (int k = 0; k < win_fill; k++)
			acc += win_ring[k];
		return acc / win_fill;
	endfunction

	function automatic mean_result_t filter_step(input logic [RAW_W-1:0] raw);
		int unsigned  angle;
		int unsigned  avg;
		int unsigned  deviation;
		mean_result_t r;
		angle = raw;
		angle = (angle * SCALE_NUM) >> SCALE_SHIFT;
		if (win_fill >= MIN_FILL) begin
			avg       = window_mean();
			deviation = (angle > avg) ? angle - avg : avg - angle;
			if (deviation > thr_reg) begin
				spike_run = spike_run + 1'b1;
				if (spike_run < lim_reg) begin
					r.angle = avg[ANGLE_W-1:0];
					r.held  = 1'b1;
					return r;
				end
				// sustained move: restart the window with this sample
				spike_run  = '0;
				win_fill   = 0;
				win_wr_ptr = 0;
			end else begin
				spike_run = '0;
			end
		end
		win_ring[win_wr_ptr] = angle[ANGLE_W-1:0];
		win_wr_ptr = (win_wr_ptr + 1) % DEPTH;
		if (win_fill < DEPTH)
			win_fill++;
		avg     = window_mean();
		r.angle = avg[ANGLE_W-1:0];
		r.held  = 1'b0;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("check failed at %0t: %s", $time, what);
		err_count++;
	endtask

	// predict on input accept, compare on result accept, watchdog
	always @(posedge clk) begin
		mean_result_t want;
		s_took <= s_tvalid && s_tready;
		m_took <= m_tvalid && m_tready;
		if (s_tvalid && s_tready)
			mean_expect_q.push_back(filter_step(s_tdata[RAW_W-1:0]));
		if (m_tvalid && m_tready) begin
			if (mean_expect_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result angle %0d held %0b", m_tdata, m_tuser));
			end else begin
				want = mean_expect_q.pop_front();
				if (m_tdata !== want.angle)
					flag_mismatch($sformatf("filtered_angle %0d, want %0d", m_tdata, want.angle));
				if (m_tuser !== want.held)
					flag_mismatch($sformatf("spike_held %0b, want %0b", m_tuser, want.held));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("angle_spike_reject_average_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// input item driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_took) begin
				// item still waiting for s_tready
			end else if (s_gap != 0) begin
				s_tvalid <= 1'b0;
				s_gap    <= s_gap - 1;
			end else if (raw_backlog.size() != 0) begin
				s_tdata  <= {{(TDATA_IN_W-RAW_W){1'b0}}, raw_backlog.pop_front()};
				s_tvalid <= 1'b1;
				s_gap    <= s_idle_on ? $urandom_range(0, 4) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: stall counts down only while a result is offered
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_took)
				m_stall_left = m_idle_on ? $urandom_range(0, 4) : 0;
			m_tready <= (m_stall_left == 0);
			if (m_tvalid && m_stall_left != 0)
				m_stall_left--;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_SPIKE_THRESHOLD)
			thr_reg = val[THR_W-1:0];
		else
			lim_reg = val[RUN_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until every expected result is back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (raw_backlog.size() != 0 || s_tvalid || mean_expect_q.size() != 0);
	endtask

	// mostly a steady angle with jitter around the threshold, plus outlier runs and noise
	task automatic queue_phase(input int unsigned n_items);
		int unsigned      jit;
		int unsigned      burst;
		int unsigned      spike;
		int unsigned      run_cap;
		int               v;
		logic [RAW_W-1:0] raw;
		jit     = (thr_reg * 16384) / 36000 + 2;
		if (jit > 4000)
			jit = 4000;
		run_cap = (lim_reg > 12) ? 12 : lim_reg;
		while (n_items != 0) begin
			case ($urandom_range(0, 9))
				0: begin
					raw = RAW_W'($urandom_range(0, 16383));
					raw_backlog.push_back(raw);
					n_items--;
				end
				1, 2: begin
					spike = $urandom_range(0, 16383);
					burst = $urandom_range(1, run_cap + 1);
					while (burst != 0 && n_items != 0) begin
						v = int'(spike) + int'($urandom_range(0, 16)) - 8;
						v = (v < 0) ? 0 : (v > 16383) ? 16383 : v;
						raw = RAW_W'(v);
						raw_backlog.push_back(raw);
						burst--;
						n_items--;
					end
					if ($urandom_range(0, 1))
						walk_base = spike;
				end
				default: begin
					v = int'(walk_base) + int'($urandom_range(0, 2 * jit)) - int'(jit);
					v = (v < 0) ? 0 : (v > 16383) ? 16383 : v;
					raw = RAW_W'(v);
					raw_backlog.push_back(raw);
					n_items--;
				end
			endcase
		end
	endtask

	initial begin
		logic [THR_W-1:0] thr_pick;
		logic [RUN_W-1:0] lim_pick;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: fill-up with no outlier test, held outliers, flush on run limit,
		// distance exactly at the threshold, alternating bit patterns
		raw_backlog = '{14'd0, 14'd16383, 14'd8191, 14'd16383, 14'd0, 14'd0, 14'd0,
			14'd0, 14'd228, 14'd229, 14'h2AAA, 14'h1555, 14'd1};
		wait_idle();

		// zero threshold and zero run limit: every outlier flushes and is taken
		write_reg(REG_SPIKE_THRESHOLD, 16'd0);
		write_reg(REG_SPIKE_RUN_LIMIT, 16'd0);
		raw_backlog = '{14'd16383, 14'd16383, 14'd16383, 14'd0, 14'd16383, 14'd1};
		wait_idle();

		// widest threshold, longest run limit
		write_reg(REG_SPIKE_THRESHOLD, 16'hFFFF);
		write_reg(REG_SPIKE_RUN_LIMIT, 16'd255);
		raw_backlog = '{14'd0, 14'd16383, 14'd0, 14'd16383};
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) begin
				thr_pick = 16'd36000;
				lim_pick = 8'd1;
			end else if (p == 1) begin
				thr_pick = 16'd0;
				lim_pick = 8'd255;
			end else begin
				case ($urandom_range(0, 5))
					0:       thr_pick = 16'd0;
					1:       thr_pick = 16'd36000;
					2:       thr_pick = THR_W'($urandom_range(1, 100));
					default: thr_pick = THR_W'($urandom_range(100, 3000));
				endcase
				case ($urandom_range(0, 5))
					0:       lim_pick = 8'd0;
					1:       lim_pick = 8'd1;
					2:       lim_pick = 8'd255;
					default: lim_pick = RUN_W'($urandom_range(2, 8));
				endcase
			end
			write_reg(REG_SPIKE_THRESHOLD, thr_pick);
			write_reg(REG_SPIKE_RUN_LIMIT, {{(CFG_DATA_W-RUN_W){1'b0}}, lim_pick});
			s_idle_on = (p % 4 != 2);
			m_idle_on = (p % 3 != 1);
			queue_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("angle_spike_reject_average_core: match");
		else
			$display("angle_spike_reject_average_core: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/asra_pkg.sv
rtl/asra_ram.sv
rtl/asra_div.sv
rtl/angle_spike_reject_average_core.sv
rtl/asra_checker.sv
sim/tb.sv
